@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int WORD_BITS = 32;   // bits of the free map per memory word
    localparam int WB        = 5;    // log2 of WORD_BITS

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN_RD  = 7'b0000100,
        S_SCAN_CHK = 7'b0001000,
        S_RMW_RD   = 7'b0010000,
        S_RMW_WR   = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

`default_nettype wire

@@ sv/bba_map_ram.sv @@
// ----------------------------------------------------------------------------
// bba_map_ram
// free map storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_ram #(
    parameter int AW = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [bba_pkg::WORD_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [bba_pkg::WORD_BITS-1:0] o_rdata
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] mem [1 << AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/buddy_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// buddy allocator over a power-of-two pool, free map held in a word memory
// ----------------------------------------------------------------------------
// An allocate or free request arrives on the s_axis channel (tuser is the
// mode: 0 allocate, 1 free) and gives exactly one result on m_axis (tuser is
// the success flag, tdata the block address, zero on failure or on free).
// Requests are handled one at a time. An allocate scans the free map word by
// word (a read, then a check of each 32-bit word) from the wanted level towards
// the root, then splits the found block down one level at a time, each split a
// read and a write of a map word; a free likewise reads and writes one map
// word per merge step, through the single read port of the free map memory.
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, a finished request holds until the output
// register empties, and s_axis_tready stays low meanwhile.
// After reset a clearing pass writes every map word, during which no request
// is taken; pool_base returns to 0x900000 and may be written through i_cfg_we
// at any idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_unit #(
    parameter int LEVELS    = 10,
    parameter int POOL_LOG2 = 26
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // req_size[26:0], free_addr[58:27], zero pad
    input  wire logic        s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // block_addr
    output logic             m_axis_tuser    // ok
);
    import bba_pkg::*;

    localparam int AW = (LEVELS > WB) ? LEVELS - WB : 1;
    localparam int XW = LEVELS + WB;
    localparam int GW = AW + WB;
    localparam int LW = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int IW = LEVELS - 1;

    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [LW-1:0]     r_lv, n_lv;
    logic [LW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_word, n_word;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_ok, n_ok;
    logic [IW-1:0]     r_fin, n_fin;
    logic [31:0]       r_base;
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [31:0]       r_out_addr, n_out_addr;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, rdata;

    bba_map_ram #(.AW(AW)) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    // request decode
    logic [26:0]   in_size;
    logic [31:0]   in_addr, in_off;
    logic          in_fit;
    logic [LW-1:0] in_lv;

    assign in_size = s_axis_tdata[26:0];
    assign in_addr = s_axis_tdata[58:27];
    assign in_off  = in_addr - r_base;

    always_comb begin
        in_fit = 1'b0;
        in_lv  = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if ({6'b0, in_size} <= (33'd1 << (POOL_LOG2 - l))) begin
                in_fit = 1'b1;
                in_lv  = LW'(l);
            end
        end
    end

    // last word of the scanned level
    logic [XW-1:0] lvl_last;
    assign lvl_last  = ((XW'(2) << r_k) - XW'(1)) >> WB;

    // lowest free bit of the current word within the level
    logic [WORD_BITS-1:0] lvl_mask, hits;
    logic [WB-1:0]        hit_pos;
    logic [GW-1:0]        hit_g;
    logic [IW-1:0]        hit_idx;

    always_comb begin
        logic [GW-1:0] g;
        for (int j = 0; j < WORD_BITS; j++) begin
            g = {r_word, WB'(j)};
            lvl_mask[j] = ((g >> r_k) == GW'(1));
        end
    end

    assign hits = rdata & lvl_mask;

    always_comb begin
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hits[j]) begin
                hit_pos = WB'(j);
            end
        end
    end

    assign hit_g   = {r_word, hit_pos};
    assign hit_idx = IW'(hit_g - (GW'(1) << r_k));

    // bit addressed by a read-modify-write step
    logic [IW-1:0]        op_idx;
    logic [XW-1:0]        op_bit;
    logic [WB-1:0]        op_pos;
    logic [WORD_BITS-1:0] op_one, op_buddy;

    assign op_idx   = (r_mode == MODE_FREE) ? r_idx : (r_idx | IW'(1));
    assign op_bit   = (XW'(1) << r_k) + XW'(op_idx);
    assign op_pos   = op_bit[WB-1:0];
    assign op_one   = WORD_BITS'(1) << op_pos;
    assign op_buddy = WORD_BITS'(1) << (op_pos ^ WB'(1));

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_lv        = r_lv;
        n_k         = r_k;
        n_idx       = r_idx;
        n_word      = r_word;
        n_clr       = r_clr;
        n_ok        = r_ok;
        n_fin       = r_fin;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_addr  = r_out_addr;
        mem_we      = 1'b0;
        mem_waddr   = r_word;
        mem_wdata   = rdata;
        mem_raddr   = r_word;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr == '0) ? WORD_BITS'(2) : '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode = s_axis_tuser;
                    n_lv   = in_lv;
                    n_k    = in_lv;
                    n_ok   = 1'b0;
                    n_fin  = '0;
                    if (!in_fit) begin
                        n_state = S_DONE;
                    end else if (s_axis_tuser == MODE_ALLOC) begin
                        n_word  = AW'((XW'(1) << in_lv) >> WB);
                        n_state = S_SCAN_RD;
                    end else if (in_off >= (32'd1 << POOL_LOG2)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = IW'(in_off >> (32'(POOL_LOG2) - 32'(in_lv)));
                        n_state = S_RMW_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (hits != '0) begin
                    // take the block, then split down keeping the left half
                    mem_we    = 1'b1;
                    mem_wdata = rdata & ~(WORD_BITS'(1) << hit_pos);
                    if (r_k == r_lv) begin
                        n_ok    = 1'b1;
                        n_fin   = hit_idx;
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_idx   = hit_idx << 1;
                        n_state = S_RMW_RD;
                    end
                end else if (AW'(lvl_last) == r_word) begin
                    if (r_k == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_word  = AW'((XW'(1) << (r_k - 1'b1)) >> WB);
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_RMW_RD: begin
                mem_raddr = op_bit[WB+AW-1:WB];
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                mem_we    = 1'b1;
                mem_waddr = op_bit[WB+AW-1:WB];
                if (r_mode == MODE_ALLOC) begin
                    mem_wdata = rdata | op_one;
                    if (r_k == r_lv) begin
                        n_ok    = 1'b1;
                        n_fin   = r_idx;
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_idx   = r_idx << 1;
                        n_state = S_RMW_RD;
                    end
                end else begin
                    // merge with the buddy while it is free
                    if (r_k != '0 && (rdata & op_buddy) != '0) begin
                        mem_wdata = rdata & ~op_one & ~op_buddy;
                        n_k       = r_k - 1'b1;
                        n_idx     = r_idx >> 1;
                        n_state   = S_RMW_RD;
                    end else begin
                        mem_wdata = rdata | op_one;
                        n_ok      = 1'b1;
                        n_state   = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_addr  = (r_ok && r_mode == MODE_ALLOC) ?
                                  r_base + (32'(r_fin) << (32'(POOL_LOG2) - 32'(r_lv))) :
                                  32'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_base      <= 32'h0090_0000;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_lv       <= n_lv;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_word     <= n_word;
        r_ok       <= n_ok;
        r_fin      <= n_fin;
        r_out_ok   <= n_out_ok;
        r_out_addr <= n_out_addr;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_ok;

endmodule

`default_nettype wire
